// ----- design/haar_pkg.sv -----
package haar_pkg;

    typedef enum logic [1:0] {
        KIND_IMAGE = 2'd0,
        KIND_RECT  = 2'd1,
        KIND_NORM  = 2'd2,
        KIND_QUERY = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_OK     = 2'd0,
        ERR_BOUNDS = 2'd1,
        ERR_DIVZ   = 2'd2
    } err_t;

    localparam int REG_HEIGHT = 0;
    localparam int REG_WIDTH  = 1;

    // one rectangle entry: weight, top, left, height, width fractions
    typedef struct packed {
        logic signed [15:0] weight;
        logic [15:0]        top;
        logic [15:0]        left;
        logic [15:0]        height;
        logic [15:0]        width;
    } rect_t;

    typedef struct packed {
        logic        done;
        logic        overflow;
        logic [31:0] quot;
    } div_res_t;

    localparam int FRAC_BITS = 29;

endpackage

// ----- design/haar_feature_from_integral_image_top.sv -----
// Haar-like feature evaluator over a stored integral image.
// Input channel (s_*): one word per item. Kind 0 writes an integral image word,
// kind 1 a rectangle of a feature, kind 2 a feature norm; each gives no result.
// Kind 3 is a query: the box and feature index produce one result word on the
// m_* channel (value, feature echo, error code); a query whose feature index is
// out of range gives no result. The single read port of the image memory (four
// corner reads per rectangle) and the bit-serial divider set a query's pace.
// One item is worked at a time. s_ready stays low while a query runs, and also
// while a finished result waits in the output register and the next query wants
// to post its own. Loads are taken while a result waits to be collected.
// Image height and width are set over the APB port; the user must write them
// only while the block is idle, which the block itself does not enforce. Reset
// sets both to 256 and clears the control state. Memory contents are not
// cleared by reset and must be loaded before use.
module haar_feature_from_integral_image_top import haar_pkg::*; #(
    parameter int IMAGE_WORDS       = 65536,
    parameter int FEATURE_COUNT     = 192,
    parameter int RECTS_PER_FEATURE = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic [15:0]        s_image_addr,
    input  logic [31:0]        s_image_value,
    input  logic [7:0]         s_feature_index,
    input  logic [1:0]         s_rect_slot,
    input  logic signed [15:0] s_rect_weight,
    input  logic [31:0]        s_norm_scale,
    input  logic [15:0]        s_pos_y,
    input  logic [15:0]        s_pos_x,
    input  logic [15:0]        s_size_h,
    input  logic [15:0]        s_size_w,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_feature_value,
    output logic [7:0]         m_feature_echo,
    output logic [1:0]         m_error_code
);

    localparam int SLOTS = FEATURE_COUNT * RECTS_PER_FEATURE;
    localparam int IW    = $clog2(IMAGE_WORDS);
    localparam int RW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NW    = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
    localparam int KW    = $clog2(RECTS_PER_FEATURE + 1);
    localparam int AXW   = 21;
    localparam int RIXW  = 14;
    localparam int ACC_W = 51 + $clog2(RECTS_PER_FEATURE);

    typedef enum logic [3:0] {
        ST_IDLE, ST_NORM, ST_MUL1, ST_MUL2, ST_CHK, ST_RECT_RD, ST_RECT,
        ST_BOUND, ST_FETCH, ST_WMUL, ST_DIV_GO, ST_DIV, ST_DONE
    } state_t;

    function automatic logic signed [17:0] corner(input logic [15:0] c,
                                                  input logic [15:0] s,
                                                  input logic [16:0] f);
        logic [32:0]        sf;
        logic signed [37:0] v;
        logic [37:0]        mag;
        logic [37:0]        rnd;
        sf  = 33'(s) * 33'(f);
        v   = $signed({6'b0, c, 16'b0}) - $signed({7'b0, s, 15'b0})
            + $signed({4'b0, sf, 1'b0}) - 38'sd524288;
        mag = v[37] ? 38'(-v) : 38'(v);
        rnd = (mag + 38'd524288) >> 20;
        return v[37] ? -$signed(rnd[17:0]) : $signed(rnd[17:0]);
    endfunction

    // ---------------- configuration ----------------
    logic [8:0] height_reg;
    logic [8:0] width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_reg <= 9'd256;
            width_reg  <= 9'd256;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == 1'(REG_HEIGHT)) begin
                height_reg <= pwdata[8:0];
            end else begin
                width_reg <= pwdata[8:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'(REG_WIDTH)) ? {23'b0, width_reg} : {23'b0, height_reg};

    // ---------------- control registers ----------------
    state_t                  state_reg;
    logic [KW-1:0]           k_reg;
    logic [2:0]              j_reg;
    logic [7:0]              feat_reg;
    logic [15:0]             py_reg, px_reg, sh_reg, sw_reg;
    logic [47:0]             p1_reg;
    logic [63:0]             div_reg;
    logic signed [15:0]      weight_reg;
    logic signed [17:0]      ht_reg, hb_reg, wl_reg, wr_reg;
    logic [AXW-1:0]          addr_reg [4];
    logic signed [34:0]      diff_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [1:0]              err_reg;
    logic signed [31:0]      value_reg;
    logic                    m_valid_reg;
    logic signed [31:0]      out_value_reg;
    logic [7:0]              out_echo_reg;
    logic [1:0]              out_err_reg;

    logic accept;
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // ---------------- memories ----------------
    logic [31:0] img_mem  [IMAGE_WORDS];
    rect_t       rect_mem [SLOTS];
    logic [31:0] norm_mem [FEATURE_COUNT];

    logic [31:0] img_q_reg;
    rect_t       rect_q_reg;
    logic [31:0] norm_q_reg;

    logic [AXW-1:0]  wr_img_addr;
    logic [RIXW-1:0] wr_rect_idx;
    logic            feat_ok;
    logic [RIXW-1:0] rd_rect_idx;
    logic [AXW-1:0]  rd_img_addr;

    assign wr_img_addr = AXW'(s_image_addr);
    assign wr_rect_idx = RIXW'(s_feature_index) * RIXW'(RECTS_PER_FEATURE) + RIXW'(s_rect_slot);
    assign feat_ok     = 11'(s_feature_index) < 11'(FEATURE_COUNT);
    assign rd_rect_idx = RIXW'(feat_reg) * RIXW'(RECTS_PER_FEATURE) + RIXW'(k_reg);
    assign rd_img_addr = addr_reg[j_reg[1:0]];

    always_ff @(posedge aclk) begin
        if (accept && s_kind == KIND_IMAGE && wr_img_addr < AXW'(IMAGE_WORDS)) begin
            img_mem[wr_img_addr[IW-1:0]] <= s_image_value;
        end
        img_q_reg <= img_mem[rd_img_addr[IW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (accept && s_kind == KIND_RECT && feat_ok &&
            4'(s_rect_slot) < 4'(RECTS_PER_FEATURE)) begin
            rect_mem[wr_rect_idx[RW-1:0]] <= '{s_rect_weight, s_pos_y, s_pos_x,
                                               s_size_h, s_size_w};
        end
        rect_q_reg <= rect_mem[rd_rect_idx[RW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (accept && s_kind == KIND_NORM && feat_ok) begin
            norm_mem[NW'(s_feature_index)] <= s_norm_scale;
        end
        norm_q_reg <= norm_mem[NW'(feat_reg)];
    end

    // ---------------- divider ----------------
    logic [ACC_W-1:0] mag;
    logic             div_start;
    div_res_t         div_res;
    logic             sat;
    logic [32:0]      rounded;

    assign mag       = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign div_start = (state_reg == ST_DIV_GO);
    assign sat       = div_res.overflow || (&div_res.quot);
    assign rounded   = ({1'b0, div_res.quot} + 33'd1) >> 1;

    haar_div #(.MAG_W(ACC_W)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mag),
        .divisor  (div_reg),
        .res      (div_res)
    );

    // ---------------- corner bounds ----------------
    logic row_t_ok, row_b_ok, col_l_ok, col_r_ok;
    logic [AXW-1:0] ca [4];
    logic           all_ok;

    assign row_t_ok = !ht_reg[17] && ht_reg < $signed({9'b0, height_reg});
    assign row_b_ok = !hb_reg[17] && hb_reg < $signed({9'b0, height_reg});
    assign col_l_ok = !wl_reg[17] && wl_reg < $signed({9'b0, width_reg});
    assign col_r_ok = !wr_reg[17] && wr_reg < $signed({9'b0, width_reg});

    // corners in order a (top-left), b (bottom-right), c (top-right), d (bottom-left)
    assign ca[0] = AXW'(ht_reg[8:0]) + AXW'(wl_reg[8:0]) * AXW'(height_reg);
    assign ca[1] = AXW'(hb_reg[8:0]) + AXW'(wr_reg[8:0]) * AXW'(height_reg);
    assign ca[2] = AXW'(ht_reg[8:0]) + AXW'(wr_reg[8:0]) * AXW'(height_reg);
    assign ca[3] = AXW'(hb_reg[8:0]) + AXW'(wl_reg[8:0]) * AXW'(height_reg);

    assign all_ok = row_t_ok && row_b_ok && col_l_ok && col_r_ok &&
                    ca[0] < AXW'(IMAGE_WORDS) && ca[1] < AXW'(IMAGE_WORDS) &&
                    ca[2] < AXW'(IMAGE_WORDS) && ca[3] < AXW'(IMAGE_WORDS);

    logic signed [34:0] img_s;
    logic               last_rect;
    assign img_s     = $signed({3'b0, img_q_reg});
    assign last_rect = (k_reg == KW'(RECTS_PER_FEATURE - 1));

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            k_reg       <= '0;
            j_reg       <= '0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept && s_kind == KIND_QUERY && feat_ok) begin
                        feat_reg  <= s_feature_index;
                        py_reg    <= s_pos_y;
                        px_reg    <= s_pos_x;
                        sh_reg    <= s_size_h;
                        sw_reg    <= s_size_w;
                        state_reg <= ST_NORM;
                    end
                end
                ST_NORM: state_reg <= ST_MUL1;
                ST_MUL1: begin
                    p1_reg    <= 48'(norm_q_reg) * 48'(sw_reg);
                    state_reg <= ST_MUL2;
                end
                ST_MUL2: begin
                    div_reg   <= 64'(p1_reg) * 64'(sh_reg);
                    state_reg <= ST_CHK;
                end
                ST_CHK: begin
                    acc_reg <= '0;
                    k_reg   <= '0;
                    if (div_reg == 64'd0) begin
                        err_reg   <= ERR_DIVZ;
                        value_reg <= '0;
                        state_reg <= ST_DONE;
                    end else begin
                        err_reg   <= ERR_OK;
                        state_reg <= ST_RECT_RD;
                    end
                end
                ST_RECT_RD: state_reg <= ST_RECT;
                ST_RECT: begin
                    if (rect_q_reg.weight == 16'sd0) begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= last_rect ? ST_DIV_GO : ST_RECT_RD;
                    end else begin
                        weight_reg <= rect_q_reg.weight;
                        ht_reg <= corner(py_reg, sh_reg, 17'(rect_q_reg.top));
                        hb_reg <= corner(py_reg, sh_reg,
                                         17'(rect_q_reg.top) + 17'(rect_q_reg.height));
                        wl_reg <= corner(px_reg, sw_reg, 17'(rect_q_reg.left));
                        wr_reg <= corner(px_reg, sw_reg,
                                         17'(rect_q_reg.left) + 17'(rect_q_reg.width));
                        state_reg <= ST_BOUND;
                    end
                end
                ST_BOUND: begin
                    for (int i = 0; i < 4; i++) begin
                        addr_reg[i] <= ca[i];
                    end
                    j_reg <= '0;
                    if (all_ok) begin
                        state_reg <= ST_FETCH;
                    end else begin
                        err_reg   <= ERR_BOUNDS;
                        value_reg <= '0;
                        state_reg <= ST_DONE;
                    end
                end
                ST_FETCH: begin
                    // data returns in the cycle after its address
                    j_reg <= j_reg + 1'b1;
                    case (j_reg)
                        3'd1: diff_reg <= img_s;
                        3'd2: diff_reg <= diff_reg + img_s;
                        3'd3: diff_reg <= diff_reg - img_s;
                        3'd4: begin
                            diff_reg  <= diff_reg - img_s;
                            state_reg <= ST_WMUL;
                        end
                        default: ;
                    endcase
                end
                ST_WMUL: begin
                    acc_reg   <= acc_reg + ACC_W'(weight_reg) * ACC_W'(diff_reg);
                    k_reg     <= k_reg + 1'b1;
                    state_reg <= last_rect ? ST_DIV_GO : ST_RECT_RD;
                end
                ST_DIV_GO: state_reg <= ST_DIV;
                ST_DIV: begin
                    if (div_res.done) begin
                        if (acc_reg[ACC_W-1]) begin
                            value_reg <= sat ? 32'sh8000_0000 : -$signed(rounded[31:0]);
                        end else begin
                            value_reg <= sat ? 32'sh7FFF_FFFF : $signed(rounded[31:0]);
                        end
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg   <= 1'b1;
                        out_value_reg <= value_reg;
                        out_echo_reg  <= feat_reg;
                        out_err_reg   <= err_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_feature_value = out_value_reg;
    assign m_feature_echo  = out_echo_reg;
    assign m_error_code    = out_err_reg;

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error_code != ERR_OK |-> m_feature_value == 32'sd0)
        else $error("error result carries a nonzero value");

    a_post_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_DONE))
        else $error("result posted outside the done step");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_res.done |-> state_reg == ST_DIV)
        else $error("divider finished while not awaited");

endmodule

// ----- design/haar_div.sv -----
module haar_div import haar_pkg::*; #(
    parameter int MAG_W = 53
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [MAG_W-1:0] dividend,
    input  logic [63:0]      divisor,
    output div_res_t         res
);

    localparam int ITER  = MAG_W + FRAC_BITS;
    localparam int CNT_W = $clog2(ITER + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             ovf_reg;
    logic [31:0]      quot_reg;
    logic [63:0]      rem_reg;
    logic [MAG_W-1:0] dvd_reg;
    logic [64:0]      trial;
    logic             ge;
    logic [64:0]      rem_next;

    assign trial    = {rem_reg, dvd_reg[MAG_W-1]};
    assign ge       = trial >= {1'b0, divisor};
    assign rem_next = ge ? trial - {1'b0, divisor} : trial;

    // one quotient bit per cycle; bits beyond 32 fold into the overflow flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ITER);
                rem_reg  <= '0;
                dvd_reg  <= dividend;
                quot_reg <= '0;
                ovf_reg  <= 1'b0;
            end else if (busy_reg) begin
                rem_reg  <= rem_next[63:0];
                dvd_reg  <= dvd_reg << 1;
                ovf_reg  <= ovf_reg | quot_reg[31];
                quot_reg <= {quot_reg[30:0], ge};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign res.done     = done_reg;
    assign res.overflow = ovf_reg;
    assign res.quot     = quot_reg;

endmodule
